@@ rtl/core/rmq_pkg.sv @@
// Shared types for the rotation matrix to quaternion core.
// No dependencies.
package rmq_pkg;

  // Which Shepperd branch produced a quaternion
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_ROW0  = 2'd1,
    BR_ROW1  = 2'd2,
    BR_ROW2  = 2'd3
  } branch_e;

endpackage

@@ rtl/core/rmq_fifo.sv @@
// Small first-word-fall-through queue, power-of-two depth.
// No dependencies.
module rmq_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + 1'b1;
      if (do_rd) rptr_q <= rptr_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (!do_wr && do_rd) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem[wptr_q] <= wdata_i;
  end

endmodule

@@ rtl/core/rmq_front.sv @@
// Front end: picks the branch, forms the clamped radicand and the three
// numerators, and queues them for the back end. Uses rmq_pkg, rmq_fifo.
module rmq_front
  import rmq_pkg::*;
#(
  parameter int unsigned W  = 16,
  parameter int unsigned F  = 14,
  parameter int unsigned QW = 2 + (W + 2) + 3 * (W + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [9*W-1:0]  mat_i,
  output logic            full_o,
  input  logic            q_pop_i,
  output logic [QW-1:0]   q_data_o,
  output logic            q_empty_o
);

  localparam int unsigned RADW = W + 3;
  localparam int unsigned RADU = W + 2;

  logic signed [RADW-1:0] m [9];
  logic signed [RADW-1:0] trace, rad, n0, n1, n2;
  logic [RADU-1:0]        radu;
  branch_e                sel;

  for (genvar k = 0; k < 9; k++) begin : g_ext
    assign m[k] = RADW'($signed(mat_i[k*W +: W]));
  end

  // m index = 3*row + col
  always_comb begin
    trace = m[0] + m[4] + m[8];
    if (trace > 0) begin
      sel = BR_TRACE;
      rad = RADW'(1 << F) + trace;
      n0  = m[7] - m[5];
      n1  = m[2] - m[6];
      n2  = m[3] - m[1];
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      sel = BR_ROW0;
      rad = RADW'(1 << F) + m[0] - m[4] - m[8];
      n0  = m[1] + m[3];
      n1  = m[2] + m[6];
      n2  = m[7] - m[5];
    end else if (m[4] > m[8]) begin
      sel = BR_ROW1;
      rad = RADW'(1 << F) + m[4] - m[0] - m[8];
      n0  = m[1] + m[3];
      n1  = m[5] + m[7];
      n2  = m[2] - m[6];
    end else begin
      sel = BR_ROW2;
      rad = RADW'(1 << F) + m[8] - m[0] - m[4];
      n0  = m[2] + m[6];
      n1  = m[5] + m[7];
      n2  = m[3] - m[1];
    end
    // non-orthonormal input: clamp radicand to one LSB
    if (rad <= 0) radu = RADU'(1);
    else          radu = rad[RADU-1:0];
  end

  rmq_fifo #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push_i),
    .wdata_i ({sel, radu, n0[W:0], n1[W:0], n2[W:0]}),
    .full_o  (full_o),
    .rd_i    (q_pop_i),
    .rdata_o (q_data_o),
    .empty_o (q_empty_o)
  );

endmodule

@@ rtl/core/rmq_back.sv @@
// Back end: pipelined square root, three pipelined dividers, saturation and
// the result queue. Uses rmq_pkg, rmq_fifo.
module rmq_back
  import rmq_pkg::*;
#(
  parameter int unsigned W  = 16,
  parameter int unsigned F  = 14,
  parameter int unsigned QW = 2 + (W + 2) + 3 * (W + 1),
  parameter int unsigned OW = 4 * W + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [QW-1:0] q_data_i,
  input  logic          q_empty_i,
  output logic          q_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [OW-1:0] res_o
);

  localparam int unsigned RADU = W + 2;
  localparam int unsigned VW   = RADU + F;
  localparam int unsigned RB   = (VW + 1) / 2;   // root bits
  localparam int unsigned VP   = 2 * RB;
  localparam int unsigned DW   = W + F + 2;      // dividend / quotient bits
  localparam int unsigned XW   = RB + W + 1;

  logic adv, o_full;

  // ---------------- square root stages ----------------
  logic            sq_vld_q  [RB+1];
  logic [VP-1:0]   sq_v_q    [RB+1];
  logic [RB:0]     sq_r_q    [RB+1];
  logic [RB-1:0]   sq_root_q [RB+1];
  branch_e         sq_sel_q  [RB+1];
  logic [W:0]      sq_mag_q  [RB+1][3];
  logic            sq_neg_q  [RB+1][3];

  logic signed [W:0] in_n [3];
  logic [RADU-1:0]   in_rad;
  branch_e           in_sel;

  assign in_sel   = branch_e'(q_data_i[QW-1 -: 2]);
  assign in_rad   = q_data_i[3*(W+1) +: RADU];
  assign in_n[0]  = $signed(q_data_i[2*(W+1) +: W+1]);
  assign in_n[1]  = $signed(q_data_i[W+1 +: W+1]);
  assign in_n[2]  = $signed(q_data_i[0 +: W+1]);
  assign q_pop_o  = adv && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_q[0] <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_v_q[0]    <= VP'(in_rad) << F;
      sq_r_q[0]    <= '0;
      sq_root_q[0] <= '0;
      sq_sel_q[0]  <= in_sel;
      for (int l = 0; l < 3; l++) begin
        sq_neg_q[0][l] <= in_n[l][W];
        sq_mag_q[0][l] <= in_n[l][W] ? (W+1)'(-in_n[l]) : in_n[l];
      end
    end
  end

  for (genvar i = 0; i < RB; i++) begin : g_sq
    logic [RB+2:0] rt, tt, df;
    logic          ge;
    assign rt = {sq_r_q[i], sq_v_q[i][VP-1 -: 2]};
    assign tt = {1'b0, sq_root_q[i], 2'b01};
    assign df = rt - tt;
    assign ge = (rt >= tt);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[i+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[i+1] <= sq_vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_v_q[i+1]    <= sq_v_q[i] << 2;
        sq_r_q[i+1]    <= ge ? df[RB:0] : rt[RB:0];
        sq_root_q[i+1] <= {sq_root_q[i][RB-2:0], ge};
        sq_sel_q[i+1]  <= sq_sel_q[i];
        sq_mag_q[i+1]  <= sq_mag_q[i];
        sq_neg_q[i+1]  <= sq_neg_q[i];
      end
    end
  end

  // ---------------- divider stages ----------------
  logic            dv_vld_q  [DW+1];
  logic [RB-1:0]   dv_root_q [DW+1];
  branch_e         dv_sel_q  [DW+1];
  logic            dv_neg_q  [DW+1][3];
  logic [DW-1:0]   dv_n_q    [DW+1][3];
  logic [RB:0]     dv_rem_q  [DW+1][3];
  logic [DW-1:0]   dv_quo_q  [DW+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_q[0] <= sq_vld_q[RB];
    end
  end

  // dividend carries the half-divisor so the quotient comes out rounded
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_root_q[0] <= sq_root_q[RB];
      dv_sel_q[0]  <= sq_sel_q[RB];
      dv_neg_q[0]  <= sq_neg_q[RB];
      for (int l = 0; l < 3; l++) begin
        dv_n_q[0][l]   <= (DW'(sq_mag_q[RB][l]) << F) + DW'(sq_root_q[RB]);
        dv_rem_q[0][l] <= '0;
        dv_quo_q[0][l] <= '0;
      end
    end
  end

  for (genvar j = 0; j < DW; j++) begin : g_dv
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_root_q[j+1] <= dv_root_q[j];
        dv_sel_q[j+1]  <= dv_sel_q[j];
        dv_neg_q[j+1]  <= dv_neg_q[j];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [RB+1:0] rt, dd, df;
      logic          ge;
      assign rt = {dv_rem_q[j][l], dv_n_q[j][l][DW-1]};
      assign dd = {1'b0, dv_root_q[j], 1'b0};
      assign df = rt - dd;
      assign ge = (rt >= dd);

      always_ff @(posedge clk_i) begin
        if (adv) begin
          dv_n_q[j+1][l]   <= dv_n_q[j][l] << 1;
          dv_rem_q[j+1][l] <= ge ? df[RB:0] : rt[RB:0];
          dv_quo_q[j+1][l] <= {dv_quo_q[j][l][DW-2:0], ge};
        end
      end
    end
  end

  // ---------------- saturation and assembly ----------------
  logic [W-1:0] lane_res [3];
  logic [W-1:0] own_res, qx, qy, qz, qw;
  logic [XW-1:0] own_x;

  for (genvar l = 0; l < 3; l++) begin : g_sat
    logic [W-1:0] qlow;
    logic         big;
    assign qlow = dv_quo_q[DW][l][W-1:0];
    assign big  = (dv_quo_q[DW][l] >> (W - 1)) != '0;
    always_comb begin
      if (big) lane_res[l] = dv_neg_q[DW][l] ? {1'b1, {(W-1){1'b0}}}
                                             : {1'b0, {(W-1){1'b1}}};
      else     lane_res[l] = dv_neg_q[DW][l] ? W'(~qlow + 1'b1) : qlow;
    end
  end

  assign own_x   = (XW'(dv_root_q[DW]) + XW'(1)) >> 1;
  assign own_res = ((own_x >> (W - 1)) != '0) ? {1'b0, {(W-1){1'b1}}} : own_x[W-1:0];

  always_comb begin
    unique case (dv_sel_q[DW])
      BR_TRACE: begin
        qx = lane_res[0]; qy = lane_res[1]; qz = lane_res[2]; qw = own_res;
      end
      BR_ROW0: begin
        qx = own_res; qy = lane_res[0]; qz = lane_res[1]; qw = lane_res[2];
      end
      BR_ROW1: begin
        qx = lane_res[0]; qy = own_res; qz = lane_res[1]; qw = lane_res[2];
      end
      default: begin
        qx = lane_res[0]; qy = lane_res[1]; qz = own_res; qw = lane_res[2];
      end
    endcase
  end

  // whole pipeline holds while a finished result cannot be queued
  assign adv = !(dv_vld_q[DW] && o_full);

  rmq_fifo #(
    .WIDTH (OW),
    .DEPTH (2)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (dv_vld_q[DW] && adv),
    .wdata_i ({qx, qy, qz, qw, dv_sel_q[DW]}),
    .full_o  (o_full),
    .rd_i    (pop_i),
    .rdata_o (res_o),
    .empty_o (empty_o)
  );

endmodule

@@ rtl/core/rotation_matrix_to_quaternion_core.sv @@
// Converts a 3x3 rotation matrix of signed fixed-point elements into a
// quaternion (Shepperd's method), one matrix per clock while pop keeps up.
// The front end classifies the matrix and queues it; the back end is a
// fully pipelined square root (one root bit per stage) followed by three
// pipelined dividers (one quotient bit per stage). Uses rmq_pkg,
// rmq_front, rmq_back.
module rotation_matrix_to_quaternion_core
  import rmq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [DATA_WIDTH-1:0] elem_r0c0_i,
  input  logic [DATA_WIDTH-1:0] elem_r0c1_i,
  input  logic [DATA_WIDTH-1:0] elem_r0c2_i,
  input  logic [DATA_WIDTH-1:0] elem_r1c0_i,
  input  logic [DATA_WIDTH-1:0] elem_r1c1_i,
  input  logic [DATA_WIDTH-1:0] elem_r1c2_i,
  input  logic [DATA_WIDTH-1:0] elem_r2c0_i,
  input  logic [DATA_WIDTH-1:0] elem_r2c1_i,
  input  logic [DATA_WIDTH-1:0] elem_r2c2_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [DATA_WIDTH-1:0] quat_x_o,
  output logic [DATA_WIDTH-1:0] quat_y_o,
  output logic [DATA_WIDTH-1:0] quat_z_o,
  output logic [DATA_WIDTH-1:0] quat_w_o,
  output logic [1:0]            branch_case_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned QW = 2 + (W + 2) + 3 * (W + 1);
  localparam int unsigned OW = 4 * W + 2;

  logic [QW-1:0] q_data;
  logic          q_empty, q_pop;
  logic [OW-1:0] res;

  rmq_front #(
    .W  (W),
    .F  (FRAC_BITS),
    .QW (QW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .mat_i     ({elem_r2c2_i, elem_r2c1_i, elem_r2c0_i,
                 elem_r1c2_i, elem_r1c1_i, elem_r1c0_i,
                 elem_r0c2_i, elem_r0c1_i, elem_r0c0_i}),
    .full_o    (full),
    .q_pop_i   (q_pop),
    .q_data_o  (q_data),
    .q_empty_o (q_empty)
  );

  rmq_back #(
    .W  (W),
    .F  (FRAC_BITS),
    .QW (QW),
    .OW (OW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_data_i  (q_data),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign quat_x_o      = res[3*W+2 +: W];
  assign quat_y_o      = res[2*W+2 +: W];
  assign quat_z_o      = res[W+2 +: W];
  assign quat_w_o      = res[2 +: W];
  assign branch_case_o = res[1:0];

endmodule

@@ rtl/core/rmq_checker.sv @@
// Port-level checks for the quaternion core, bound to the top level.
// Uses rmq_pkg.
module rmq_checker
  import rmq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  empty,
  input logic                  pop,
  input logic [DATA_WIDTH-1:0] quat_x_o,
  input logic [DATA_WIDTH-1:0] quat_y_o,
  input logic [DATA_WIDTH-1:0] quat_z_o,
  input logic [DATA_WIDTH-1:0] quat_w_o,
  input logic [1:0]            branch_case_o
);

  // the component of the chosen branch comes from a root and is never negative
  a_own_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |->
      (branch_case_o == BR_TRACE && !quat_w_o[DATA_WIDTH-1]) ||
      (branch_case_o == BR_ROW0  && !quat_x_o[DATA_WIDTH-1]) ||
      (branch_case_o == BR_ROW1  && !quat_y_o[DATA_WIDTH-1]) ||
      (branch_case_o == BR_ROW2  && !quat_z_o[DATA_WIDTH-1]))
    else $error("own quaternion component negative");

  // nothing can be waiting in the first cycle out of reset
  a_empty_after_reset: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> empty)
    else $error("result present right after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(quat_x_o) && $stable(quat_y_o) &&
                       $stable(quat_z_o) && $stable(quat_w_o) &&
                       $stable(branch_case_o))
    else $error("waiting result changed");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_rmq_checker (.*);

@@ dv/rotation_matrix_to_quaternion_core_tb.sv @@
// Self-checking testbench for rotation_matrix_to_quaternion_core: random and
// directed matrices, quaternion predicted in-bench and compared per field.
// Depends on rmq_pkg and the core RTL.
module rotation_matrix_to_quaternion_core_tb;
  import rmq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 16;
  localparam int FB = 14;
  localparam int IDLE_LIMIT = 20000;

  typedef logic signed [DW-1:0] elem_t;
  typedef struct packed {
    elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;
  typedef struct packed {
    elem_t   qx, qy, qz, qw;
    branch_e br;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  matrix_t drv_mat = '0;
  logic [DW-1:0] qx_o, qy_o, qz_o, qw_o;
  logic [1:0] br_o;

  matrix_t pending_q[$];
  quat_t   quat_exp_q[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  always #2 clk_i = ~clk_i;

  rotation_matrix_to_quaternion_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk_i, .rst_ni, .push, .full,
    .elem_r0c0_i(drv_mat.m00), .elem_r0c1_i(drv_mat.m01), .elem_r0c2_i(drv_mat.m02),
    .elem_r1c0_i(drv_mat.m10), .elem_r1c1_i(drv_mat.m11), .elem_r1c2_i(drv_mat.m12),
    .elem_r2c0_i(drv_mat.m20), .elem_r2c1_i(drv_mat.m21), .elem_r2c2_i(drv_mat.m22),
    .empty, .pop,
    .quat_x_o(qx_o), .quat_y_o(qy_o), .quat_z_o(qz_o), .quat_w_o(qw_o),
    .branch_case_o(br_o)
  );

  function automatic longint sat_w(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r = 0;
    while ((r + 1) * (r + 1) <= v) r = r + 1;
    return r;
  endfunction

  // round(num * 2^FB / s), half away from zero
  function automatic longint scaled_div(longint num, longint s);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< FB) + (s >>> 1)) / s;
    return sat_w((num < 0) ? -q : q);
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad, root, s, own;
    quat_t r;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      r.br = BR_TRACE; rad = (1 <<< FB) + tr;
    end else if (a00 > a11 && a00 > a22) begin
      r.br = BR_ROW0; rad = (1 <<< FB) + a00 - a11 - a22;
    end else if (a11 > a22) begin
      r.br = BR_ROW1; rad = (1 <<< FB) + a11 - a00 - a22;
    end else begin
      r.br = BR_ROW2; rad = (1 <<< FB) + a22 - a00 - a11;
    end
    if (rad <= 0) rad = 1;  // non-orthonormal input clamp
    root = int_sqrt(rad <<< FB);
    s = root * 2;
    own = sat_w((root + 1) >>> 1);
    case (r.br)
      BR_TRACE: begin
        r.qx = elem_t'(scaled_div(a21 - a12, s)); r.qy = elem_t'(scaled_div(a02 - a20, s));
        r.qz = elem_t'(scaled_div(a10 - a01, s)); r.qw = elem_t'(own);
      end
      BR_ROW0: begin
        r.qx = elem_t'(own); r.qy = elem_t'(scaled_div(a01 + a10, s));
        r.qz = elem_t'(scaled_div(a02 + a20, s)); r.qw = elem_t'(scaled_div(a21 - a12, s));
      end
      BR_ROW1: begin
        r.qx = elem_t'(scaled_div(a01 + a10, s)); r.qy = elem_t'(own);
        r.qz = elem_t'(scaled_div(a12 + a21, s)); r.qw = elem_t'(scaled_div(a02 - a20, s));
      end
      default: begin
        r.qx = elem_t'(scaled_div(a02 + a20, s)); r.qy = elem_t'(scaled_div(a12 + a21, s));
        r.qz = elem_t'(own); r.qw = elem_t'(scaled_div(a10 - a01, s));
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && !(push && full)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_mat <= pending_q.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
    pop <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (push && !full) begin
        quat_exp_q.push_back(matrix_to_quat(drv_mat));
      end
      if (pop && !empty) begin
        if (quat_exp_q.size() == 0) begin
          report_mismatch("unexpected transaction", br_o, -1);
        end else begin
          quat_t e;
          e = quat_exp_q.pop_front();
          if ($signed(qx_o) != e.qx) report_mismatch("quat_x", $signed(qx_o), e.qx);
          if ($signed(qy_o) != e.qy) report_mismatch("quat_y", $signed(qy_o), e.qy);
          if ($signed(qz_o) != e.qz) report_mismatch("quat_z", $signed(qz_o), e.qz);
          if ($signed(qw_o) != e.qw) report_mismatch("quat_w", $signed(qw_o), e.qw);
          if (br_o != e.br) report_mismatch("branch_case", br_o, e.br);
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic elem_t rand_elem();
    case ($urandom_range(5))
      0: return elem_t'(-32768);
      1: return elem_t'(32767);
      2: return elem_t'($urandom_range(16384) - 8192);
      default: return elem_t'($urandom);
    endcase
  endfunction

  // near-orthonormal: signed permutation matrix with small noise
  function automatic matrix_t rand_rotation();
    elem_t e[9];
    int p[3], t;
    matrix_t m;
    p = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      int j;
      j = $urandom_range(i);
      t = p[i]; p[i] = p[j]; p[j] = t;
    end
    for (int i = 0; i < 9; i++) e[i] = elem_t'(int'($urandom_range(800)) - 400);
    for (int i = 0; i < 3; i++)
      e[i*3 + p[i]] = elem_t'(($urandom_range(1) ? 16384 : -16384)
                              + int'($urandom_range(600)) - 300);
    m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return m;
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    if ($urandom_range(99) < 70) return rand_rotation();
    m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    return m;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || push || quat_exp_q.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    matrix_t m;
    elem_t one_q = elem_t'(16384);
    elem_t mone_q = elem_t'(-16384);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: identity, each row branch, ties, extremes
    pending_q.push_back({one_q, 16'sd0, 16'sd0, 16'sd0, one_q, 16'sd0, 16'sd0, 16'sd0, one_q});
    pending_q.push_back({one_q, 16'sd0, 16'sd0, 16'sd0, mone_q, 16'sd0, 16'sd0, 16'sd0, mone_q});
    pending_q.push_back({mone_q, 16'sd0, 16'sd0, 16'sd0, one_q, 16'sd0, 16'sd0, 16'sd0, mone_q});
    pending_q.push_back({mone_q, 16'sd0, 16'sd0, 16'sd0, mone_q, 16'sd0, 16'sd0, 16'sd0, one_q});
    pending_q.push_back('0);  // zero trace, all tied
    pending_q.push_back({mone_q, 16'sd5, 16'sd0, 16'sd0, mone_q, 16'sd0, 16'sd0, 16'sd0, elem_t'(-20000)});
    pending_q.push_back({elem_t'(-9000), 16'sd0, 16'sd0, 16'sd0, elem_t'(-9000), 16'sd0,
                         16'sd0, 16'sd0, elem_t'(-20000)});
    // alternating full-scale elements
    pending_q.push_back({elem_t'(-32768), elem_t'(32767), elem_t'(-32768), elem_t'(32767),
                         elem_t'(-32768), elem_t'(32767), elem_t'(-32768), elem_t'(32767),
                         elem_t'(-32768)});
    pending_q.push_back({9{elem_t'(32767)}});
    pending_q.push_back({9{elem_t'(-32768)}});
    pending_q.push_back({16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1});
    pending_q.push_back({16'sd1, elem_t'(32767), elem_t'(32767), elem_t'(-32768), 16'sd0,
                         elem_t'(32767), elem_t'(-32768), elem_t'(-32768), 16'sd0});
    pending_q.push_back({elem_t'(-32768), elem_t'(32767), elem_t'(32767), elem_t'(32767),
                         elem_t'(32767), elem_t'(-32768), elem_t'(32767), elem_t'(-32768),
                         elem_t'(-32768)});
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int i = 0; i < 325; i++) begin
        m = rand_matrix();
        pending_q.push_back(m);
      end
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && quat_exp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
